// ===== src/incdf_pkg.sv =====
// ----------------------------------------------------------------------------
// incdf_pkg
// Fixed constants of the inverse normal CDF approximation: Q24 polynomial
// coefficients, the Q30 value of 2 ln 2 and the internal fraction widths.
// ----------------------------------------------------------------------------
package incdf_pkg;

    localparam int QI = 24;
    localparam int QL = 30;
    localparam int CW = 32;

    localparam logic [63:0] C0_W = (64'd2515517 * 64'd16777216 + 64'd500000) / 64'd1000000;
    localparam logic [63:0] C1_W = (64'd802853 * 64'd16777216 + 64'd500000) / 64'd1000000;
    localparam logic [63:0] C2_W = (64'd10328 * 64'd16777216 + 64'd500000) / 64'd1000000;
    localparam logic [63:0] D1_W = (64'd1432788 * 64'd16777216 + 64'd500000) / 64'd1000000;
    localparam logic [63:0] D2_W = (64'd189269 * 64'd16777216 + 64'd500000) / 64'd1000000;
    localparam logic [63:0] D3_W = (64'd1308 * 64'd16777216 + 64'd500000) / 64'd1000000;

    localparam logic [CW-1:0] C0 = C0_W[CW-1:0];
    localparam logic [CW-1:0] C1 = C1_W[CW-1:0];
    localparam logic [CW-1:0] C2 = C2_W[CW-1:0];
    localparam logic [CW-1:0] D1 = D1_W[CW-1:0];
    localparam logic [CW-1:0] D2 = D2_W[CW-1:0];
    localparam logic [CW-1:0] D3 = D3_W[CW-1:0];

    localparam logic [30:0] TWO_LN2 = 31'd1488522236;

    typedef logic [15:0] t_dev;

endpackage

// ===== src/inverse_normal_cdf_approx.sv =====
// ----------------------------------------------------------------------------
// inverse_normal_cdf_approx
// Maps a uniform probability code to a standard normal deviate with 12
// fraction bits, through a fully pipelined log, square root, rational
// polynomial and divider.
// ----------------------------------------------------------------------------
// The block accepts one item per clock while the output is not stalled,
// and returns one result per item, in order. Items pass through the
// thirty log squaring stages, the bit-per-stage square root of RB bits (RB
// is 28 at the default PROB_BITS) and the bit-per-stage divider. A stall
// at the output holds the whole pipeline.
module inverse_normal_cdf_approx
    import incdf_pkg::*;
#(
    parameter int PROB_BITS = 32,
    parameter int FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_prob_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_deviate,
    output logic        o_infinite_flag
);

    localparam int PW   = PROB_BITS;
    localparam int KW   = $clog2(PW);
    localparam int LIW  = $clog2(PW + 1);
    localparam int LS   = QL;
    localparam int UW   = LIW + 31;
    localparam int RB   = (UW + 2 * QI - QL + 1) / 2;
    localparam int VW   = 2 * RB;
    localparam int RW   = RB + 3;
    localparam int QB   = CW;
    localparam int SH   = QI - FRAC_BITS;
    localparam int RND  = (SH > 0) ? (1 << (SH - 1)) : 0;
    localparam int XW   = CW + 2;
    localparam int IDX_DL = 8 + LS + RB + QB;
    localparam int N    = IDX_DL + 3;

    logic          w_en;
    logic [PW-1:0] w_code;

    logic          r_vld [N];
    logic          r_zero [N];
    logic          r_up [N];

    logic [PW-1:0] r_q;
    logic [PW-1:0] r_bq;
    logic [KW-1:0] r_bk;

    logic [30:0]   r_lm [LS+1];
    logic [LS-1:0] r_lf [LS+1];
    logic [KW-1:0] r_lk [LS+1];

    logic [VW-1:0] r_sv [RB+1];
    logic [RW-1:0] r_srem [RB+1];
    logic [RB-1:0] r_sroot [RB+1];

    logic [RB-1:0] r_pt [4];
    logic [63:0]   r_pa [2];
    logic [63:0]   r_pb [4];
    logic [CW-1:0] r_pnum [2];

    logic [CW:0]   r_drem [QB+1];
    logic [QB-1:0] r_dlo [QB+1];
    logic [CW-1:0] r_dden [QB+1];
    logic [QB-1:0] r_dq [QB+1];
    logic [RB-1:0] r_dt [QB+1];

    logic          r_fneg;
    logic [XW-1:0] r_fa;
    logic [15:0]   r_dev;

    logic [KW-1:0]       n_k;
    logic [PW+29:0]      n_ext;
    logic [LIW+29:0]     n_l2;
    logic [60:0]         n_pf;
    logic [UW-1:0]       n_u;
    logic [63:0]         n_sq [LS];
    logic [RW-1:0]       n_rs [RB];
    logic [RW-1:0]       n_tr [RB];
    logic [CW:0]         n_ds [QB];
    logic signed [XW-1:0] n_x;
    logic [XW-1:0]       n_ra;
    logic [XW-1:0]       n_sat;

    generate
        if (PW > 32) begin : g_wide
            assign w_code = {{(PW - 32){1'b0}}, i_prob_code};
        end else begin : g_narrow
            assign w_code = i_prob_code[PW-1:0];
        end
    endgenerate

    assign w_en    = !r_vld[N-1] || i_ready;
    assign o_ready = w_en;

    always_comb begin
        n_k = '0;
        for (int b = 0; b < PW; b++) begin
            if (r_q[b]) begin
                n_k = KW'(b);
            end
        end
        n_ext = {r_bq, 30'b0} >> r_bk;
        for (int i = 0; i < LS; i++) begin
            n_sq[i] = (64'(r_lm[i]) * 64'(r_lm[i])) >> QL;
        end
        n_l2 = {LIW'(PW) - LIW'(r_lk[LS]), 30'b0} - (LIW + 30)'(r_lf[LS]);
        n_pf = 61'(n_l2[29:0]) * 61'(TWO_LN2);
        n_u  = UW'(n_l2[LIW+29:30]) * UW'(TWO_LN2) + UW'(n_pf[60:30]);
        for (int j = 0; j < RB; j++) begin
            n_rs[j] = {r_srem[j][RW-3:0], r_sv[j][VW-1:VW-2]};
            n_tr[j] = {1'b0, r_sroot[j], 2'b01};
        end
        for (int j = 0; j < QB; j++) begin
            n_ds[j] = {r_drem[j][CW-1:0], r_dlo[j][QB-1]};
        end
        n_x = XW'(signed'({1'b0, r_dt[QB]})) - XW'(signed'({1'b0, r_dq[QB]}));
        n_ra = (r_fa + XW'(RND)) >> SH;
        if (r_fneg) begin
            n_sat = (n_ra > XW'(32768)) ? XW'(32768) : n_ra;
        end else begin
            n_sat = (n_ra > XW'(32767)) ? XW'(32767) : n_ra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < N; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero[0] <= (w_code == '0);
            r_up[0]   <= w_code > {1'b1, {(PW - 1){1'b0}}};
            r_q       <= (w_code > {1'b1, {(PW - 1){1'b0}}}) ? (PW'(0) - w_code) : w_code;
            for (int s = 1; s < N; s++) begin
                r_zero[s] <= r_zero[s-1];
                r_up[s]   <= r_up[s-1];
            end

            r_bq <= r_q;
            r_bk <= n_k;

            r_lm[0] <= n_ext[30:0];
            r_lf[0] <= '0;
            r_lk[0] <= r_bk;
            for (int i = 0; i < LS; i++) begin
                r_lk[i+1] <= r_lk[i];
                if (n_sq[i][31]) begin
                    r_lm[i+1] <= n_sq[i][31:1];
                    r_lf[i+1] <= r_lf[i] | (LS'(1) << (LS - 1 - i));
                end else begin
                    r_lm[i+1] <= n_sq[i][30:0];
                    r_lf[i+1] <= r_lf[i];
                end
            end

            r_sv[0]    <= VW'(n_u) << (2 * QI - QL);
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            for (int j = 0; j < RB; j++) begin
                r_sv[j+1] <= r_sv[j] << 2;
                if (n_rs[j] >= n_tr[j]) begin
                    r_srem[j+1]  <= n_rs[j] - n_tr[j];
                    r_sroot[j+1] <= {r_sroot[j][RB-2:0], 1'b1};
                end else begin
                    r_srem[j+1]  <= n_rs[j];
                    r_sroot[j+1] <= {r_sroot[j][RB-2:0], 1'b0};
                end
            end

            r_pt[0] <= r_sroot[RB];
            r_pa[0] <= 64'(C2) * 64'(r_sroot[RB]);
            r_pb[0] <= 64'(D3) * 64'(r_sroot[RB]);

            r_pt[1] <= r_pt[0];
            r_pa[1] <= 64'(C1 + CW'(r_pa[0] >> QI)) * 64'(r_pt[0]);
            r_pb[1] <= 64'(D2 + CW'(r_pb[0] >> QI)) * 64'(r_pt[0]);

            r_pt[2]   <= r_pt[1];
            r_pnum[0] <= C0 + CW'(r_pa[1] >> QI);
            r_pb[2]   <= 64'(D1 + CW'(r_pb[1] >> QI)) * 64'(r_pt[1]);

            r_pt[3]   <= r_pt[2];
            r_pnum[1] <= r_pnum[0];
            r_pb[3]   <= r_pb[2];

            r_drem[0] <= (CW + 1)'(r_pnum[1] >> (QB - QI));
            r_dlo[0]  <= QB'({r_pnum[1], {QI{1'b0}}});
            r_dden[0] <= (CW'(1) << QI) + CW'(r_pb[3] >> QI);
            r_dq[0]   <= '0;
            r_dt[0]   <= r_pt[3];
            for (int j = 0; j < QB; j++) begin
                r_dlo[j+1]  <= r_dlo[j] << 1;
                r_dden[j+1] <= r_dden[j];
                r_dt[j+1]   <= r_dt[j];
                if (n_ds[j] >= (CW + 1)'(r_dden[j])) begin
                    r_drem[j+1] <= n_ds[j] - (CW + 1)'(r_dden[j]);
                    r_dq[j+1]   <= {r_dq[j][QB-2:0], 1'b1};
                end else begin
                    r_drem[j+1] <= n_ds[j];
                    r_dq[j+1]   <= {r_dq[j][QB-2:0], 1'b0};
                end
            end

            if (r_up[IDX_DL]) begin
                r_fneg <= n_x < 0;
                r_fa   <= (n_x < 0) ? XW'(-n_x) : XW'(n_x);
            end else begin
                r_fneg <= n_x > 0;
                r_fa   <= (n_x > 0) ? XW'(n_x) : XW'(-n_x);
            end

            if (r_zero[IDX_DL+1]) begin
                r_dev <= 16'h8000;
            end else if (r_fneg) begin
                r_dev <= 16'(-n_sat);
            end else begin
                r_dev <= 16'(n_sat);
            end
        end
    end

    assign o_valid         = r_vld[N-1];
    assign o_deviate       = r_dev;
    assign o_infinite_flag = r_zero[N-1];

endmodule
